[rtl/tcw_pkg.sv]
// Shared types and constants for the text console character writer.
// Screen geometry, field widths, function and control character codes.
// No dependencies; tcw_if.sv, tcw_ctrl.sv and the top level refer to this package by scoped names.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELL_COUNT);

	// Field widths of the channels
	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int RROW_W  = 5;
	localparam int RCOL_W  = 7;
	localparam int OROW_W  = 5;
	localparam int OCOL_W  = 7;
	localparam int LIN_W   = 11;
	localparam int CELL_W  = ATTR_W + CHAR_W;

	// Address constants
	localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Control characters and fill values
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

	// Request from the controller to the screen memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

[rtl/tcw_if.sv]
// Channel interfaces of the text console writer: command in, result out.
// Valid/ready handshake; depends on tcw_pkg for field widths.
interface tcw_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::FUNC_W-1:0]  func;
	logic [tcw_pkg::CHAR_W-1:0]  char_code;
	logic [tcw_pkg::RROW_W-1:0]  read_row;
	logic [tcw_pkg::RCOL_W-1:0]  read_column;

	modport source (output valid, func, char_code, read_row, read_column, input ready);
	modport sink (input valid, func, char_code, read_row, read_column, output ready);
endinterface

interface tcw_res_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::OROW_W-1:0]  cursor_row;
	logic [tcw_pkg::OCOL_W-1:0]  cursor_column;
	logic [tcw_pkg::LIN_W-1:0]   cursor_linear;
	logic [tcw_pkg::CELL_W-1:0]  cell_value;

	modport source (output valid, cursor_row, cursor_column, cursor_linear, cell_value,
		input ready);
	modport sink (input valid, cursor_row, cursor_column, cursor_linear, cell_value,
		output ready);
endinterface

[rtl/tcw_screen_ram.sv]
// Generic simple dual-port RAM for the screen cells: one write, one read port.
// Read data registered and held while no read is issued.
// No dependencies.
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tcw_ctrl.sv]
// Console sequencer: cursor, put/clear/read handling, scroll and fill sweeps.
// Drives the screen memory through a registered write stage; owns the result register.
// Depends on tcw_pkg and the channel interfaces in tcw_if.sv.
module tcw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tcw_pkg::ATTR_W-1:0]  attr,
	tcw_cmd_if.sink                     cmd,
	tcw_res_if.source                   res,
	output tcw_pkg::ram_req_t           ram_req,
	input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PRINT,
		ST_SCROLL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	localparam logic [2:0] TAB_SPACES = 3'd4;

	state_t                          state_q;
	logic [tcw_pkg::ROW_W-1:0]       row_q;
	logic [tcw_pkg::COL_W-1:0]       col_q;
	logic [tcw_pkg::ADDR_W-1:0]      sweep_q;
	logic [2:0]                      tabs_q;
	logic                            cell_sel_q;

	// write stage
	logic                            wr_en_s1;
	logic                            wr_copy_s1;
	logic [tcw_pkg::ADDR_W-1:0]      wr_addr_s1;
	logic [tcw_pkg::CELL_W-1:0]      wr_data_s1;

	// result register
	logic                            res_valid_q;
	logic [tcw_pkg::OROW_W-1:0]      res_row_q;
	logic [tcw_pkg::OCOL_W-1:0]      res_col_q;
	logic [tcw_pkg::LIN_W-1:0]       res_lin_q;
	logic [tcw_pkg::CELL_W-1:0]      res_cell_q;

	logic                            accept;
	logic [tcw_pkg::ADDR_W-1:0]      cur_addr;
	logic [tcw_pkg::ADDR_W-1:0]      rd_addr;
	logic                            rd_hit;
	logic                            col_last;
	logic                            row_last;
	logic [tcw_pkg::COL_W-1:0]       adv_col;
	logic [tcw_pkg::ROW_W-1:0]       adv_row;
	logic                            adv_scroll;
	logic [tcw_pkg::CELL_W-1:0]      blank;

	// handshake: no new transaction while a write is still in flight
	assign cmd.ready = (state_q == ST_IDLE) && !wr_en_s1;
	assign accept    = cmd.valid && cmd.ready;

	// cursor address and read address
	assign cur_addr = tcw_pkg::ADDR_W'(row_q) * tcw_pkg::ROW_STRIDE
		+ tcw_pkg::ADDR_W'(col_q);
	assign rd_hit = (32'(cmd.read_row) < 32'(tcw_pkg::ROWS))
		&& (32'(cmd.read_column) < 32'(tcw_pkg::COLUMNS));
	assign rd_addr = tcw_pkg::ADDR_W'(cmd.read_row) * tcw_pkg::ROW_STRIDE
		+ tcw_pkg::ADDR_W'(cmd.read_column);

	// cursor advance after one printed cell
	assign col_last   = (col_q == tcw_pkg::LAST_COL);
	assign row_last   = (row_q == tcw_pkg::LAST_ROW);
	assign adv_col    = col_last ? '0 : col_q + tcw_pkg::COL_W'(1);
	assign adv_row    = (col_last && !row_last) ? row_q + tcw_pkg::ROW_W'(1) : row_q;
	assign adv_scroll = col_last && row_last;

	assign blank = {attr, tcw_pkg::CH_SPACE};

	// memory request: reads issued directly, writes from the write stage
	always_comb begin
		ram_req.re = ((state_q == ST_IDLE) && accept && (cmd.func == tcw_pkg::FUNC_READ)
			&& rd_hit)
			|| ((state_q == ST_SCROLL) && (sweep_q < tcw_pkg::LAST_ROW_BASE));
		ram_req.raddr = (state_q == ST_SCROLL) ? sweep_q + tcw_pkg::ROW_STRIDE : rd_addr;
		ram_req.we    = wr_en_s1;
		ram_req.waddr = wr_addr_s1;
		ram_req.wdata = wr_copy_s1 ? ram_rdata : wr_data_s1;
	end

	// result channel
	assign res.valid         = res_valid_q;
	assign res.cursor_row    = res_row_q;
	assign res.cursor_column = res_col_q;
	assign res.cursor_linear = res_lin_q;
	assign res.cell_value    = res_cell_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			sweep_q     <= '0;
			tabs_q      <= '0;
			cell_sel_q  <= 1'b0;
			wr_en_s1    <= 1'b0;
			wr_copy_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			wr_en_s1   <= 1'b0;
			wr_copy_s1 <= 1'b0;
			if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				// clearing pass after reset: every cell to zero
				ST_INIT: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= sweep_q;
					wr_data_s1 <= '0;
					if (sweep_q == tcw_pkg::LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + tcw_pkg::ADDR_W'(1);
					end
				end

				ST_IDLE: begin
					if (accept) begin
						cell_sel_q <= 1'b0;
						state_q    <= ST_DONE;
						case (cmd.func)
							tcw_pkg::FUNC_PUT: begin
								if (cmd.char_code == tcw_pkg::CH_NEWLINE) begin
									col_q <= '0;
									if (row_last) begin
										sweep_q <= '0;
										tabs_q  <= '0;
										state_q <= ST_SCROLL;
									end else begin
										row_q <= row_q + tcw_pkg::ROW_W'(1);
									end
								end else if (cmd.char_code == tcw_pkg::CH_RETURN) begin
									col_q <= '0;
								end else if (cmd.char_code == tcw_pkg::CH_BACKSPACE) begin
									// step back one linear cell, except at the origin
									if (cur_addr != '0) begin
										wr_en_s1   <= 1'b1;
										wr_addr_s1 <= cur_addr - tcw_pkg::ADDR_W'(1);
										wr_data_s1 <= blank;
										if (col_q != '0) begin
											col_q <= col_q - tcw_pkg::COL_W'(1);
										end else begin
											row_q <= row_q - tcw_pkg::ROW_W'(1);
											col_q <= tcw_pkg::LAST_COL;
										end
									end
								end else if (cmd.char_code == tcw_pkg::CH_TAB) begin
									tabs_q  <= TAB_SPACES;
									state_q <= ST_PRINT;
								end else begin
									wr_en_s1   <= 1'b1;
									wr_addr_s1 <= cur_addr;
									wr_data_s1 <= {attr, cmd.char_code};
									row_q      <= adv_row;
									col_q      <= adv_col;
									if (adv_scroll) begin
										sweep_q <= '0;
										tabs_q  <= '0;
										state_q <= ST_SCROLL;
									end
								end
							end
							tcw_pkg::FUNC_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							tcw_pkg::FUNC_READ: begin
								cell_sel_q <= rd_hit;
							end
							default: begin
							end
						endcase
					end
				end

				// tab: one space per cycle, may scroll in between
				ST_PRINT: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= cur_addr;
					wr_data_s1 <= blank;
					row_q      <= adv_row;
					col_q      <= adv_col;
					tabs_q     <= tabs_q - 3'd1;
					if (adv_scroll) begin
						sweep_q <= '0;
						state_q <= ST_SCROLL;
					end else if (tabs_q == 3'd1) begin
						state_q <= ST_DONE;
					end
				end

				// scroll: copy each cell from one row below, blank the last row
				ST_SCROLL: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= sweep_q;
					wr_copy_s1 <= (sweep_q < tcw_pkg::LAST_ROW_BASE);
					wr_data_s1 <= blank;
					if (sweep_q == tcw_pkg::LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= (tabs_q != '0) ? ST_PRINT : ST_DONE;
					end else begin
						sweep_q <= sweep_q + tcw_pkg::ADDR_W'(1);
					end
				end

				// clear: blank every cell
				ST_CLEAR: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= sweep_q;
					wr_data_s1 <= blank;
					if (sweep_q == tcw_pkg::LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_DONE;
					end else begin
						sweep_q <= sweep_q + tcw_pkg::ADDR_W'(1);
					end
				end

				// load the result once the output register is free
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_row_q   <= tcw_pkg::OROW_W'(row_q);
						res_col_q   <= tcw_pkg::OCOL_W'(col_q);
						res_lin_q   <= tcw_pkg::LIN_W'(cur_addr);
						res_cell_q  <= cell_sel_q ? ram_rdata : '0;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/text_console_character_writer_top.sv]
// Text console character writer, top level: attribute register, sequencer, screen memory.
// Put, return, newline, backspace, read and unused codes: the accepting edge moves to the done
// state, which loads the result register once it is free; no command is taken until then.
// Tab first writes its spaces; a scroll (newline or wrap on the last row) or a clear sweeps every
// cell. After reset a clearing pass over all ROWS*COLUMNS cells (2000) zeroes the memory while
// cmd.ready stays low; attribute writes are taken during it. Depends on tcw_pkg, tcw_if.sv.
module text_console_character_writer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	tcw_cmd_if.sink                     cmd,
	tcw_res_if.source                   res,
	input  logic                        text_attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute_data
);

	logic [tcw_pkg::ATTR_W-1:0]  attr_q;
	tcw_pkg::ram_req_t           ram_req;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (text_attribute_we) begin
			attr_q <= text_attribute_data;
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.cmd       (cmd),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	tcw_screen_ram #(
		.DEPTH (tcw_pkg::CELL_COUNT),
		.WIDTH (tcw_pkg::CELL_W)
	) u_screen_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule
